@@ hdl/tfn_pkg.sv @@
package tfn_pkg;

    localparam int CW        = 32;          // coordinate width
    localparam int FRAC_BITS = 16;          // fraction bits of Q16.16
    localparam int EW        = CW + 1;      // edge difference
    localparam int PW        = 2 * EW;      // edge product
    localparam int NW        = PW + 1;      // cross component, signed
    localparam int MW        = PW;          // cross magnitude
    localparam int SUMW      = CW + 2;      // sum of three coordinates
    localparam int AW        = 30;          // normalized magnitude
    localparam int SQW       = 2 * AW;      // square of one component
    localparam int SW        = SQW + 2;     // sum of squares
    localparam int RW        = SW / 2;      // square root
    localparam int RMW       = RW + 3;      // root remainder
    localparam int LW        = 31;          // segment length
    localparam int QW        = LW;          // offset quotient
    localparam int DW        = RW + QW;     // dividend a*L + r/2
    localparam int LZW       = 7;           // leading zero count
    localparam int NCH       = (MW + 7) / 8;
    localparam int PADW      = NCH * 8;

    // floor(x/3) = (x * ceil(2^36/3)) >> 36, exact for x < 2^35
    localparam int KW        = 35;
    localparam int DIV3_SH   = 36;
    localparam logic [KW-1:0] DIV3_K = 35'h5_5555_5556;

    localparam logic [LW-1:0] SEG_RESET = LW'((((3 << FRAC_BITS) * 2) + 10) / 20);

    // paddr[2] selects the register word
    localparam logic REG_SEG_LENGTH = 1'b0;

    localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SAT_LO = {{(SUMW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [NW-1:0] cross_t;
    typedef logic [AW-1:0]        amag_t;

    typedef struct packed {
        coord_t [2:0] mid;
        logic   [2:0] neg;
        logic         degen;
        logic         last;
    } side_t;

    function automatic coord_t sat_coord(input logic signed [SUMW-1:0] v);
        coord_t r;
        if (v > SAT_HI)
            r = SAT_HI[CW-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[CW-1:0];
        else
            r = v[CW-1:0];
        return r;
    endfunction

    function automatic logic [2:0] lzc8(input logic [7:0] v);
        logic [2:0] n;
        n = 3'd7;
        for (int b = 0; b < 8; b++)
        begin
            if (v[b])
                n = 3'(7 - b);
        end
        return n;
    endfunction

endpackage

@@ hdl/triangle_face_normal_segment.sv @@
// Pipeline, from input transfer to result: front end, normalize, square root,
//   scale/divide/output.
// Throughput: one triangle per cycle; every stage is a register stage and the
//   whole pipe holds only while an output result waits to be taken.
// Reset (rst_n, async, active low): pipe valids clear, segment_length = 0.3.
module triangle_face_normal_segment (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // third_x, third_y, third_z (32 bits each, from bit 0 up)
    input  logic [287:0] s_tdata,
    input  logic         s_tlast,       // last_face
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // mid_x, mid_y, mid_z, tip_x, tip_y, tip_z (32 bits each, from bit 0 up)
    output logic [191:0] m_tdata,
    output logic         m_tuser,       // degenerate
    output logic         m_tlast,       // last_out
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tfn_pkg::*;

    logic [LW-1:0]  seg_reg;
    logic           ce;

    coord_t [8:0]   vin;
    cross_t [2:0]   xprod;
    side_t          side_f, side_n, side_s;
    logic           v_f, v_n, v_s;
    amag_t [2:0]    amag_n, amag_s;
    logic [SW-1:0]  ssum;
    logic [RW-1:0]  root;
    coord_t [2:0]   mid_o, tip_o;

    // Register port: single word, decoded on paddr[2].
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEG_LENGTH) ? {1'b0, seg_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_reg <= SEG_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_SEG_LENGTH))
            seg_reg <= pwdata[LW-1:0];
    end

    // Pipe advances whenever the output register is empty or being drained.
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
            vin[k] = s_tdata[CW*k +: CW];
    end

    // Edges, centroid, exact cross product.
    tfn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid && s_tready),
        .vin       (vin),
        .in_last   (s_tlast),
        .out_valid (v_f),
        .xprod     (xprod),
        .side      (side_f)
    );

    // Common normalizing shift to a 30-bit magnitude, sum of squares.
    tfn_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v_f),
        .xprod     (xprod),
        .side_in   (side_f),
        .out_valid (v_n),
        .amag      (amag_n),
        .ssum      (ssum),
        .side_out  (side_n)
    );

    // Integer square root, one root bit per stage.
    tfn_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v_n),
        .ssum      (ssum),
        .amag_in   (amag_n),
        .side_in   (side_n),
        .out_valid (v_s),
        .root      (root),
        .amag_out  (amag_s),
        .side_out  (side_s)
    );

    // Offset = round(a * L / r), signed and added to the centroid with saturation.
    tfn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v_s),
        .root      (root),
        .amag      (amag_s),
        .side_in   (side_s),
        .seg_len   (seg_reg),
        .out_valid (m_tvalid),
        .mid       (mid_o),
        .tip       (tip_o),
        .degen     (m_tuser),
        .last      (m_tlast)
    );

    assign m_tdata = {tip_o, mid_o};

endmodule

@@ hdl/tfn_front.sv @@
module tfn_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ce,
    input  logic                   in_valid,
    input  tfn_pkg::coord_t [8:0]  vin,
    input  logic                   in_last,
    output logic                   out_valid,
    output tfn_pkg::cross_t [2:0]  xprod,
    output tfn_pkg::side_t         side
);
    import tfn_pkg::*;

    // stage 1: edges and coordinate sums
    logic signed [EW-1:0]   e1_reg [3], e2_reg [3], e1_next [3], e2_next [3];
    logic signed [SUMW-1:0] sum_reg [3], sum_next [3];
    logic                   last1_reg, v1_reg;
    // stage 2: edge products, centroid magnitude / 3
    logic signed [PW-1:0]   p_reg [6], p_next [6];
    logic [CW:0]            q_reg [3], q_next [3];
    logic [2:0]             cneg_reg;
    logic                   last2_reg, v2_reg;
    // stage 3: cross components, signed centroid
    cross_t [2:0]           cross_reg, cross_next;
    side_t                  side_reg, side_next;
    logic                   v3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_next[i]  = EW'($signed(vin[3+i])) - EW'($signed(vin[i]));
            e2_next[i]  = EW'($signed(vin[6+i])) - EW'($signed(vin[i]));
            sum_next[i] = SUMW'($signed(vin[i])) + SUMW'($signed(vin[3+i]))
                        + SUMW'($signed(vin[6+i]));
        end
    end

    always_comb
    begin
        logic [SUMW-1:0]    cmag;
        logic [SUMW-1:0]    cx;
        logic [SUMW+KW-1:0] cprod;
        p_next[0] = e1_reg[1] * e2_reg[2];
        p_next[1] = e1_reg[2] * e2_reg[1];
        p_next[2] = e1_reg[2] * e2_reg[0];
        p_next[3] = e1_reg[0] * e2_reg[2];
        p_next[4] = e1_reg[0] * e2_reg[1];
        p_next[5] = e1_reg[1] * e2_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            cmag      = sum_reg[i][SUMW-1] ? -sum_reg[i] : sum_reg[i];
            cx        = cmag + 1'b1;
            cprod     = (SUMW+KW)'(cx) * (SUMW+KW)'(DIV3_K);
            q_next[i] = cprod[DIV3_SH +: CW+1];
        end
    end

    always_comb
    begin
        logic signed [SUMW-1:0] cq;
        cross_next[0] = NW'(p_reg[0]) - NW'(p_reg[1]);
        cross_next[1] = NW'(p_reg[2]) - NW'(p_reg[3]);
        cross_next[2] = NW'(p_reg[4]) - NW'(p_reg[5]);
        side_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            cq = $signed({1'b0, q_reg[i]});
            if (cneg_reg[i])
                cq = -cq;
            side_next.mid[i] = sat_coord(cq);
        end
        side_next.last = last2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i]   <= e1_next[i];
                e2_reg[i]   <= e2_next[i];
                sum_reg[i]  <= sum_next[i];
                q_reg[i]    <= q_next[i];
                cneg_reg[i] <= sum_reg[i][SUMW-1];
            end
            for (int i = 0; i < 6; i++)
                p_reg[i] <= p_next[i];
            last1_reg <= in_last;
            last2_reg <= last1_reg;
            cross_reg <= cross_next;
            side_reg  <= side_next;
        end
    end

    assign out_valid = v3_reg;
    assign xprod     = cross_reg;
    assign side      = side_reg;

endmodule

@@ hdl/tfn_norm.sv @@
module tfn_norm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ce,
    input  logic                        in_valid,
    input  tfn_pkg::cross_t [2:0]       xprod,
    input  tfn_pkg::side_t              side_in,
    output logic                        out_valid,
    output tfn_pkg::amag_t [2:0]        amag,
    output logic [tfn_pkg::SW-1:0]      ssum,
    output tfn_pkg::side_t              side_out
);
    import tfn_pkg::*;

    logic [5:0]             v_reg;
    // stage 4: magnitudes
    logic [MW-1:0]          mag4_reg [3], mag4_next [3];
    logic [MW-1:0]          or4_reg, or4_next;
    side_t                  side4_reg, side4_next;
    // stage 5: per-byte leading zeros
    logic [MW-1:0]          mag5_reg [3];
    logic [NCH-1:0]         nz5_reg, nz5_next;
    logic [2:0]             lz5_reg [NCH], lz5_next [NCH];
    side_t                  side5_reg;
    // stage 6: common shift
    logic [MW-1:0]          mag6_reg [3];
    logic [LZW-1:0]         lz6_reg, lz6_next;
    side_t                  side6_reg;
    // stage 7..9: aligned magnitudes, squares, sum
    amag_t [2:0]            a7_reg, a7_next, a8_reg, a9_reg;
    logic [SQW-1:0]         sq8_reg [3], sq8_next [3];
    logic [SW-1:0]          s9_reg;
    side_t                  side7_reg, side8_reg, side9_reg;

    always_comb
    begin
        side4_next = side_in;
        or4_next   = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag4_next[i]      = xprod[i][NW-1] ? MW'(-xprod[i]) : MW'(xprod[i]);
            side4_next.neg[i] = xprod[i][NW-1];
            or4_next          = or4_next | mag4_next[i];
        end
        side4_next.degen = (or4_next == '0);
    end

    always_comb
    begin
        logic [PADW-1:0] padded;
        padded = {or4_reg, {(PADW-MW){1'b0}}};
        for (int k = 0; k < NCH; k++)
        begin
            nz5_next[k] = |padded[PADW-1-8*k -: 8];
            lz5_next[k] = lzc8(padded[PADW-1-8*k -: 8]);
        end
    end

    always_comb
    begin
        lz6_next = '0;
        for (int k = NCH - 1; k >= 0; k--)
        begin
            if (nz5_reg[k])
                lz6_next = LZW'(8 * k) + LZW'(lz5_reg[k]);
        end
    end

    always_comb
    begin
        logic [MW-1:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            sh          = mag6_reg[i] << lz6_reg;
            a7_next[i]  = sh[MW-1 -: AW];
            sq8_next[i] = SQW'(a7_reg[i]) * SQW'(a7_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ce)
            v_reg <= {v_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag4_reg[i] <= mag4_next[i];
                mag5_reg[i] <= mag4_reg[i];
                mag6_reg[i] <= mag5_reg[i];
                sq8_reg[i]  <= sq8_next[i];
            end
            for (int k = 0; k < NCH; k++)
                lz5_reg[k] <= lz5_next[k];
            or4_reg   <= or4_next;
            nz5_reg   <= nz5_next;
            lz6_reg   <= lz6_next;
            a7_reg    <= a7_next;
            a8_reg    <= a7_reg;
            a9_reg    <= a8_reg;
            s9_reg    <= SW'(sq8_reg[0]) + SW'(sq8_reg[1]) + SW'(sq8_reg[2]);
            side4_reg <= side4_next;
            side5_reg <= side4_reg;
            side6_reg <= side5_reg;
            side7_reg <= side6_reg;
            side8_reg <= side7_reg;
            side9_reg <= side8_reg;
        end
    end

    assign out_valid = v_reg[5];
    assign amag      = a9_reg;
    assign ssum      = s9_reg;
    assign side_out  = side9_reg;

endmodule

@@ hdl/tfn_sqrt.sv @@
module tfn_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [tfn_pkg::SW-1:0]      ssum,
    input  tfn_pkg::amag_t [2:0]        amag_in,
    input  tfn_pkg::side_t              side_in,
    output logic                        out_valid,
    output logic [tfn_pkg::RW-1:0]      root,
    output tfn_pkg::amag_t [2:0]        amag_out,
    output tfn_pkg::side_t              side_out
);
    import tfn_pkg::*;

    // one result bit per stage, most significant first
    logic [RW-1:0]  v_reg;
    logic [RMW-1:0] rem_reg [RW], rem_next [RW];
    logic [RW-1:0]  root_reg [RW], root_next [RW];
    logic [SW-1:0]  s_reg [RW];
    amag_t [2:0]    a_reg [RW];
    side_t          side_reg [RW];

    always_comb
    begin
        logic [RMW-1:0] rin;
        logic [RW-1:0]  oin;
        logic [SW-1:0]  sin;
        logic [RMW-1:0] cur;
        logic [RMW-1:0] tst;
        for (int j = 0; j < RW; j++)
        begin
            if (j == 0)
            begin
                rin = '0;
                oin = '0;
                sin = ssum;
            end
            else
            begin
                rin = rem_reg[j-1];
                oin = root_reg[j-1];
                sin = s_reg[j-1];
            end
            cur = {rin[RMW-3:0], sin[2*(RW-1-j) +: 2]};
            tst = {1'b0, oin, 2'b01};
            if (cur >= tst)
            begin
                rem_next[j]  = cur - tst;
                root_next[j] = {oin[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = cur;
                root_next[j] = {oin[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ce)
            v_reg <= {v_reg[RW-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int j = 0; j < RW; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                if (j == 0)
                begin
                    s_reg[j]    <= ssum;
                    a_reg[j]    <= amag_in;
                    side_reg[j] <= side_in;
                end
                else
                begin
                    s_reg[j]    <= s_reg[j-1];
                    a_reg[j]    <= a_reg[j-1];
                    side_reg[j] <= side_reg[j-1];
                end
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign amag_out  = a_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

@@ hdl/tfn_div.sv @@
module tfn_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [tfn_pkg::RW-1:0]      root,
    input  tfn_pkg::amag_t [2:0]        amag,
    input  tfn_pkg::side_t              side_in,
    input  logic [tfn_pkg::LW-1:0]      seg_len,
    output logic                        out_valid,
    output tfn_pkg::coord_t [2:0]       mid,
    output tfn_pkg::coord_t [2:0]       tip,
    output logic                        degen,
    output logic                        last
);
    import tfn_pkg::*;

    // multiply stage
    logic [DW-1:0]  nm_reg [3];
    logic [RW-1:0]  rm_reg;
    side_t          sidem_reg;
    logic           vm_reg;
    // restoring division, one quotient bit per stage, three lanes
    logic [RW-1:0]  rem_reg [QW][3], rem_next [QW][3];
    logic [QW-1:0]  q_reg [QW][3], q_next [QW][3];
    logic [DW-1:0]  n_reg [QW][3];
    logic [RW-1:0]  r_reg [QW];
    side_t          side_reg [QW];
    logic [QW-1:0]  v_reg;
    // output register
    coord_t [2:0]   mid_reg, tip_reg, tip_next;
    logic           degen_reg, last_reg, vo_reg;

    always_comb
    begin
        logic [RW-1:0] rin;
        logic [QW-1:0] qin;
        logic [DW-1:0] nin;
        logic [RW-1:0] rr;
        logic [RW:0]   cur;
        logic [RW:0]   diff;
        for (int j = 0; j < QW; j++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (j == 0)
                begin
                    nin = nm_reg[l];
                    rin = nin[DW-1 -: RW];
                    qin = '0;
                    rr  = rm_reg;
                end
                else
                begin
                    nin = n_reg[j-1][l];
                    rin = rem_reg[j-1][l];
                    qin = q_reg[j-1][l];
                    rr  = r_reg[j-1];
                end
                cur  = {rin, nin[QW-1-j]};
                diff = cur - {1'b0, rr};
                if (cur >= {1'b0, rr})
                begin
                    rem_next[j][l] = diff[RW-1:0];
                    q_next[j][l]   = {qin[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j][l] = cur[RW-1:0];
                    q_next[j][l]   = {qin[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        logic [SUMW-1:0] em;
        logic [SUMW-1:0] eo;
        logic [SUMW-1:0] t;
        for (int l = 0; l < 3; l++)
        begin
            em = SUMW'($signed(side_reg[QW-1].mid[l]));
            eo = {{(SUMW-QW){1'b0}}, q_reg[QW-1][l]};
            t  = side_reg[QW-1].neg[l] ? em - eo : em + eo;
            if (side_reg[QW-1].degen)
                tip_next[l] = side_reg[QW-1].mid[l];
            else
                tip_next[l] = sat_coord($signed(t));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end
        else if (ce)
        begin
            vm_reg <= in_valid;
            v_reg  <= {v_reg[QW-2:0], vm_reg};
            vo_reg <= v_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int l = 0; l < 3; l++)
                nm_reg[l] <= DW'(amag[l]) * DW'(seg_len) + DW'(root >> 1);
            rm_reg    <= root;
            sidem_reg <= side_in;
            for (int j = 0; j < QW; j++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[j][l] <= rem_next[j][l];
                    q_reg[j][l]   <= q_next[j][l];
                    n_reg[j][l]   <= (j == 0) ? nm_reg[l] : n_reg[j-1][l];
                end
                r_reg[j]    <= (j == 0) ? rm_reg : r_reg[j-1];
                side_reg[j] <= (j == 0) ? sidem_reg : side_reg[j-1];
            end
            mid_reg   <= side_reg[QW-1].mid;
            tip_reg   <= tip_next;
            degen_reg <= side_reg[QW-1].degen;
            last_reg  <= side_reg[QW-1].last;
        end
    end

    assign out_valid = vo_reg;
    assign mid       = mid_reg;
    assign tip       = tip_reg;
    assign degen     = degen_reg;
    assign last      = last_reg;

endmodule

@@ hdl/tfn_chk.sv @@
module tfn_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic         m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_degen_tip: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[191:96] == m_tdata[95:0])
        else $error("degenerate face with tip off the centroid");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input stalled with free output");

endmodule

bind triangle_face_normal_segment tfn_chk u_chk (.*);
